// ----- rtl/dcsg_pkg.sv -----
// Package for the drive command safety gate: payload, config and queue types,
// gear, action and register index codes. No dependencies.
`timescale 1ns / 1ps

package dcsg_pkg;

  // Gear codes
  localparam logic [7:0] GEAR_DISABLE = 8'd0;
  localparam logic [7:0] GEAR_PARK    = 8'd1;
  localparam logic [7:0] GEAR_REVERSE = 8'd2;
  localparam logic [7:0] GEAR_NEUTRAL = 8'd3;
  localparam logic [7:0] GEAR_DRIVE   = 8'd4;

  // Transaction actions
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_SEND  = 1'b1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FWD_GEAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_GEAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_REV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd5;

  // Result queue depth
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [7:0]  fwd_gear_code;
    logic [7:0]  rev_gear_code;
    logic        rev_permit;
    logic [14:0] max_speed;
    logic [14:0] max_steer;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [31:0]        now_ms;
    logic               time_bad;
    logic               values_bad;
    logic [7:0]         gear_in;
    logic signed [15:0] speed_in;
    logic signed [15:0] steer_in;
    logic [7:0]         brake_in;
  } req_t;

  typedef struct packed {
    logic [7:0]         gear_out;
    logic [14:0]        speed_out;
    logic signed [15:0] steer_out;
    logic [7:0]         brake_out;
    logic               is_stop;
  } rsp_t;

  localparam rsp_t STOP_RSP = '{
    gear_out:  GEAR_DRIVE,
    speed_out: 15'd0,
    steer_out: 16'sd0,
    brake_out: 8'd0,
    is_stop:   1'b1
  };

endpackage

// ----- rtl/dcsg_stream_if.sv -----
// Valid/ready stream interface carrying one payload of a given type.
// No dependencies; payload type set at instantiation.
`timescale 1ns / 1ps

interface dcsg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/dcsg_front.sv -----
// Front end: accepts transactions, runs the time and command checks, keeps
// the stored command and pushes send results to the queue. Uses dcsg_pkg.
`timescale 1ns / 1ps

module dcsg_front
  import dcsg_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  input  req_t in_data_i,
  output logic in_ready_o,
  input  logic q_full_i,
  output logic push_o,
  output rsp_t push_data_o
);

  localparam int unsigned NOW_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic                 cmd_valid_q, cmd_valid_d;
  logic [7:0]           cmd_gear_q, cmd_gear_d;
  logic [14:0]          cmd_speed_q, cmd_speed_d;
  logic signed [15:0]   cmd_steer_q, cmd_steer_d;
  logic [7:0]           cmd_brake_q, cmd_brake_d;
  logic [TIME_BITS-1:0] cmd_time_q, cmd_time_d;
  logic [TIME_BITS-1:0] last_time_q, last_time_d;
  logic                 time_seen_q, time_seen_d;

  logic                 acc;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] age;
  logic                 time_ok, stale, send_live;
  logic                 is_drive, is_rev, is_still, reject, store_ok, drop;
  logic                 moving;
  logic [14:0]          speed_clamp;
  logic signed [16:0]   steer_x, lim_x;
  logic signed [15:0]   steer_clamp;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    now_w    = TIME_BITS'(in_data_i.now_ms[NOW_BITS-1:0]);
    time_ok  = !in_data_i.time_bad && !(time_seen_q && (now_w < last_time_q));

    is_drive = (in_data_i.gear_in == GEAR_DRIVE) && (cfg_i.fwd_gear_code == GEAR_DRIVE);
    is_rev   = (in_data_i.gear_in == GEAR_REVERSE) && (cfg_i.rev_gear_code == GEAR_REVERSE);
    is_still = (in_data_i.gear_in == GEAR_DISABLE) || (in_data_i.gear_in == GEAR_PARK) ||
               (in_data_i.gear_in == GEAR_NEUTRAL);
    reject   = (in_data_i.gear_in > GEAR_DRIVE) || (is_rev && !cfg_i.rev_permit) ||
               (!is_drive && !is_rev && !is_still) ||
               (is_still && (in_data_i.speed_in != 16'sd0));
    store_ok = time_ok && !in_data_i.values_bad && !in_data_i.speed_in[15] && !reject;
    moving   = (in_data_i.speed_in != 16'sd0) && !is_still;

    // speed is non-negative here, so its low 15 bits hold the magnitude
    speed_clamp = (in_data_i.speed_in[14:0] > cfg_i.max_speed) ? cfg_i.max_speed
                                                                : in_data_i.speed_in[14:0];
    steer_x = {in_data_i.steer_in[15], in_data_i.steer_in};
    lim_x   = signed'({2'b00, cfg_i.max_steer});
    if (steer_x > lim_x) begin
      steer_clamp = lim_x[15:0];
    end else if (steer_x < -lim_x) begin
      steer_clamp = 16'(-lim_x);
    end else begin
      steer_clamp = in_data_i.steer_in;
    end

    age       = now_w - cmd_time_q;
    stale     = age > TIME_BITS'(cfg_i.timeout_ms);
    send_live = time_ok && cmd_valid_q && !stale;

    drop = (in_data_i.action == ACT_STORE) ? !store_ok : !send_live;
  end

  // state update
  always_comb begin
    cmd_valid_d = cmd_valid_q;
    cmd_gear_d  = cmd_gear_q;
    cmd_speed_d = cmd_speed_q;
    cmd_steer_d = cmd_steer_q;
    cmd_brake_d = cmd_brake_q;
    cmd_time_d  = cmd_time_q;
    last_time_d = last_time_q;
    time_seen_d = time_seen_q;
    if (acc) begin
      time_seen_d = !in_data_i.time_bad;
      if (!in_data_i.time_bad) begin
        last_time_d = now_w;
      end
      if (drop) begin
        cmd_valid_d = 1'b0;
        cmd_gear_d  = GEAR_DRIVE;
        cmd_speed_d = '0;
        cmd_steer_d = '0;
        cmd_brake_d = '0;
      end else if (in_data_i.action == ACT_STORE) begin
        cmd_valid_d = 1'b1;
        cmd_gear_d  = in_data_i.gear_in;
        cmd_brake_d = in_data_i.brake_in;
        cmd_speed_d = moving ? speed_clamp : '0;
        cmd_steer_d = moving ? steer_clamp : '0;
        cmd_time_d  = now_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      cmd_gear_q  <= GEAR_DRIVE;
      cmd_speed_q <= '0;
      cmd_steer_q <= '0;
      cmd_brake_q <= '0;
      cmd_time_q  <= '0;
      last_time_q <= '0;
      time_seen_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      cmd_gear_q  <= cmd_gear_d;
      cmd_speed_q <= cmd_speed_d;
      cmd_steer_q <= cmd_steer_d;
      cmd_brake_q <= cmd_brake_d;
      cmd_time_q  <= cmd_time_d;
      last_time_q <= last_time_d;
      time_seen_q <= time_seen_d;
    end
  end

  always_comb begin
    push_o = acc && (in_data_i.action == ACT_SEND);
    if (send_live) begin
      push_data_o = '{
        gear_out:  cmd_gear_q,
        speed_out: cmd_speed_q,
        steer_out: cmd_steer_q,
        brake_out: cmd_brake_q,
        is_stop:   1'b0
      };
    end else begin
      push_data_o = STOP_RSP;
    end
  end

  a_time_bad_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.time_bad |=> !cmd_valid_q && !time_seen_q)
    else $error("time_bad transaction left a command or time stamp in place");

  a_live_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> push_data_o.is_stop || cmd_valid_q)
    else $error("live result sent with no stored command");

  a_bad_values_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_data_i.action == ACT_STORE) && in_data_i.values_bad |=> !cmd_valid_q)
    else $error("store with bad values kept a command");

endmodule

// ----- rtl/dcsg_queue.sv -----
// Back end: short result queue that drives the output stream.
// Uses dcsg_pkg for rsp_t and QDEPTH.
`timescale 1ns / 1ps

module dcsg_queue
  import dcsg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rsp_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  output rsp_t out_data_o,
  input  logic out_ready_i
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  rsp_t          mem_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign full_o      = (cnt_q == CW'(QDEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result pushed into a full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push_i |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

// ----- rtl/drive_command_safety_gate_core.sv -----
// Drive command safety gate, top level. A send result is written into the
// result queue when its transaction is accepted and shows on rsp_o once
// older results have been taken. Throughput: one transaction per cycle while
// the result queue is not full; the two-entry queue lets the front end run
// while a result waits. Reset (rst_ni low, asynchronous): no stored command,
// time history cleared, queue empty, configuration back to its defaults.
`timescale 1ns / 1ps

module drive_command_safety_gate_core
  import dcsg_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dcsg_stream_if.sink           req_i,
  dcsg_stream_if.source         rsp_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the gate is
  // idle (not enforced by the block); no shadowing. Unknown indexes are ignored.
  // ---------------------------------------------------------------------------
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FWD_GEAR:  cfg_d.fwd_gear_code = cfg_wdata_i[7:0];
        CFG_REV_GEAR:  cfg_d.rev_gear_code = cfg_wdata_i[7:0];
        CFG_ALLOW_REV: cfg_d.rev_permit    = cfg_wdata_i[0];
        CFG_MAX_SPEED: cfg_d.max_speed     = cfg_wdata_i[14:0];
        CFG_MAX_STEER: cfg_d.max_steer     = cfg_wdata_i[14:0];
        CFG_TIMEOUT:   cfg_d.timeout_ms    = cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_gear_code <= GEAR_DRIVE;
      cfg_q.rev_gear_code <= GEAR_REVERSE;
      cfg_q.rev_permit    <= 1'b0;
      cfg_q.max_speed     <= 15'd1000;
      cfg_q.max_steer     <= 15'd2500;
      cfg_q.timeout_ms    <= 16'd500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: checks each transaction, updates the stored command and, for a
  // send, decides between the stored command and the stop command.
  // ---------------------------------------------------------------------------
  logic q_full;
  logic push;
  rsp_t push_data;
  logic in_ready;
  logic out_valid;
  rsp_t out_data;

  dcsg_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (req_i.valid),
    .in_data_i   (req_i.payload),
    .in_ready_o  (in_ready),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  assign req_i.ready = in_ready;

  // ---------------------------------------------------------------------------
  // Back end: results wait here until the sink takes them.
  // ---------------------------------------------------------------------------
  dcsg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (rsp_o.ready)
  );

  assign rsp_o.valid   = out_valid;
  assign rsp_o.payload = out_data;

endmodule

// ----- tb/sv/tb_drive_command_safety_gate_core.sv -----
// Self-checking bench for drive_command_safety_gate_core: directed and random
// store/send transactions against an in-bench predictor, over several settings.
// Depends on dcsg_pkg, dcsg_stream_if and the gate core.
`timescale 1ns / 1ps

module tb_drive_command_safety_gate_core;
  import dcsg_pkg::*;

  // Spare register indexes: the gate must ignore writes to them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 6;

  // Clock, reset and everything the bench drives start at known values
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  req_valid   = 1'b0;
  req_t                  req_data    = '0;
  logic                  rsp_rdy     = 1'b0;

  dcsg_stream_if #(.payload_t(req_t)) req_if ();
  dcsg_stream_if #(.payload_t(rsp_t)) rsp_if ();

  assign req_if.valid   = req_valid;
  assign req_if.payload = req_data;
  assign rsp_if.ready   = rsp_rdy;

  drive_command_safety_gate_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bench-side state
  // ---------------------------------------------------------------------------
  req_t        pending_q[$];   // transactions waiting for the driver
  rsp_t        result_q[$];    // predicted send results, oldest first
  int unsigned req_issued  = 0; // transactions put on the bus by the driver
  int unsigned req_accepts = 0; // transactions taken by the gate
  int unsigned mismatches  = 0;
  int          req_gap     = 0;
  int          rsp_hold    = 0;
  bit          idling_on   = 1'b1;
  logic [31:0] stim_ms     = '0; // running clock of the stimulus generator

  // Predictor copy of the gate: settings and the held command
  cfg_t               cfg_model;
  logic               held_valid;
  logic [7:0]         held_gear;
  logic [14:0]        held_speed;
  logic signed [15:0] held_steer;
  logic [7:0]         held_brake;
  logic [31:0]        held_ms;
  logic [31:0]        last_ms;
  logic               clock_seen;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void drop_held();
    held_valid = 1'b0;
    held_gear  = GEAR_DRIVE;
    held_speed = '0;
    held_steer = '0;
    held_brake = '0;
  endfunction

  // Clock plausibility: a bad or backward timestamp kills the held command.
  // After a bad one any timestamp is taken as the new reference.
  function automatic bit clock_check(input logic bad, input logic [31:0] now);
    if (bad) begin
      drop_held();
      clock_seen = 1'b0;
      return 1'b0;
    end
    if (clock_seen && now < last_ms) begin
      drop_held();
      last_ms = now;
      return 1'b0;
    end
    last_ms    = now;
    clock_seen = 1'b1;
    return 1'b1;
  endfunction

  function automatic void gate_predict(input req_t r);
    bit   ok, fwd, rev, still;
    int   spd, str, lim;
    logic [31:0] age;
    rsp_t e;
    ok = clock_check(r.time_bad, r.now_ms);
    if (r.action == ACT_STORE) begin
      spd   = int'($signed(r.speed_in));
      fwd   = (r.gear_in == GEAR_DRIVE) && (cfg_model.fwd_gear_code == GEAR_DRIVE);
      rev   = (r.gear_in == GEAR_REVERSE) && (cfg_model.rev_gear_code == GEAR_REVERSE);
      still = (r.gear_in == GEAR_DISABLE) || (r.gear_in == GEAR_PARK) ||
              (r.gear_in == GEAR_NEUTRAL);
      if (!ok || r.values_bad || spd < 0 || r.gear_in > GEAR_DRIVE ||
          (rev && !cfg_model.rev_permit) || (!fwd && !rev && !still) ||
          (still && spd != 0)) begin
        drop_held();
      end else begin
        held_gear  = r.gear_in;
        held_brake = r.brake_in;
        if (spd == 0 || still) begin
          // standing still: no speed, wheels straight
          held_speed = '0;
          held_steer = '0;
        end else begin
          lim = int'(cfg_model.max_steer);
          str = int'($signed(r.steer_in));
          held_speed = (spd > int'(cfg_model.max_speed)) ? cfg_model.max_speed : spd[14:0];
          if (str > lim) str = lim;
          else if (str < -lim) str = -lim;
          held_steer = str[15:0];
        end
        held_ms    = r.now_ms;
        held_valid = 1'b1;
      end
    end else begin
      e = STOP_RSP;
      if (ok && held_valid) begin
        age = r.now_ms - held_ms; // wraps modulo 2^32
        if (age > 32'(cfg_model.timeout_ms)) begin
          drop_held(); // stale command: gone for good
        end else begin
          e.gear_out  = held_gear;
          e.speed_out = held_speed;
          e.steer_out = held_steer;
          e.brake_out = held_brake;
          e.is_stop   = 1'b0;
        end
      end
      result_q.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes at the falling edge, one transaction at a time
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(negedge clk_i) begin : req_driver
    // free once the presented transaction has been taken (or none is up)
    if (rst_ni && (!req_valid || req_accepts == req_issued)) begin
      if (req_gap > 0) begin
        req_gap--;
        req_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_data  <= pending_q.pop_front();
        req_valid <= 1'b1;
        req_issued++;
        req_gap = idling_on ? pick_gap() : 0;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result sink back-pressure
  always @(negedge clk_i) begin : rsp_driver
    if (!rst_ni) begin
      rsp_rdy <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_rdy <= 1'b0;
    end else begin
      rsp_rdy <= 1'b1;
      if (idling_on && $urandom_range(0, 99) < 25) rsp_hold = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitors: sample at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : req_monitor
    if (rst_ni && req_valid && req_if.ready) begin
      gate_predict(req_data);
      req_accepts++;
    end
  end

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : rsp_monitor
    rsp_t got, want;
    if (rst_ni && rsp_if.valid && rsp_rdy) begin
      got = rsp_if.payload;
      if (result_q.size() == 0) begin
        $error("result with no send transaction pending: gear %0d speed %0d stop %0b",
               got.gear_out, got.speed_out, got.is_stop);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        check_field("gear_out",  {24'd0, want.gear_out},  {24'd0, got.gear_out});
        check_field("speed_out", {17'd0, want.speed_out}, {17'd0, got.speed_out});
        check_field("steer_out", 32'($signed(want.steer_out)), 32'($signed(got.steer_out)));
        check_field("brake_out", {24'd0, want.brake_out}, {24'd0, got.brake_out});
        check_field("is_stop",   {31'd0, want.is_stop},   {31'd0, got.is_stop});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic req_t mk(input logic act, input logic [31:0] now, input logic tbad,
                              input logic vbad, input logic [7:0] gear,
                              input logic signed [15:0] speed,
                              input logic signed [15:0] steer, input logic [7:0] brake);
    req_t r;
    r.action     = act;
    r.now_ms     = now;
    r.time_bad   = tbad;
    r.values_bad = vbad;
    r.gear_in    = gear;
    r.speed_in   = speed;
    r.steer_in   = steer;
    r.brake_in   = brake;
    return r;
  endfunction

  // Mostly sane store/send traffic on a forward-running clock, with some
  // bad or backward timestamps and fully random noise mixed in.
  function automatic req_t random_item();
    req_t r;
    int   k, adv, w, s;
    r   = '0;
    adv = int'(cfg_model.timeout_ms) * 3 / 2 + 2;
    k   = $urandom_range(0, 99);
    if (k < 3) begin
      r.time_bad = 1'b1;
      r.now_ms   = $urandom;
    end else begin
      if (k < 6) stim_ms = stim_ms - $urandom_range(1, 50);
      else if (k < 8) stim_ms = $urandom;
      else stim_ms = stim_ms + $urandom_range(0, adv);
      r.now_ms = stim_ms;
    end

    r.brake_in = 8'($urandom);
    k = $urandom_range(0, 99);
    if (k < 15) begin
      // noise
      r.action     = 1'($urandom);
      r.values_bad = 1'($urandom);
      r.gear_in    = 8'($urandom);
      r.speed_in   = 16'($urandom);
      r.steer_in   = 16'($urandom);
    end else if (k < 55) begin
      r.action   = ACT_SEND;
      r.gear_in  = 8'($urandom);
      r.speed_in = 16'($urandom);
      r.steer_in = 16'($urandom);
    end else begin
      r.action     = ACT_STORE;
      r.values_bad = ($urandom_range(0, 49) == 0);
      case ($urandom_range(0, 7))
        0, 1, 2, 3: r.gear_in = GEAR_DRIVE;
        4, 5:       r.gear_in = GEAR_REVERSE;
        6:          r.gear_in = GEAR_PARK;
        default:    r.gear_in = $urandom_range(0, 1) ? GEAR_NEUTRAL : GEAR_DISABLE;
      endcase
      if (r.gear_in == GEAR_DRIVE || r.gear_in == GEAR_REVERSE) begin
        k = $urandom_range(0, 99);
        if (k < 10) s = 0;
        else if (k < 70) s = $urandom_range(0, 2 * int'(cfg_model.max_speed) + 1);
        else if (k < 97) s = $urandom_range(0, 32767);
        else s = -int'($urandom_range(1, 32768));
        if (s > 32767) s = 32767;
        r.speed_in = s[15:0];
      end else begin
        // still gears need zero speed; now and then break that rule
        r.speed_in = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'sd0;
      end
      if ($urandom_range(0, 1)) begin
        r.steer_in = 16'($urandom);
      end else begin
        w = int'(cfg_model.max_steer) * 3 / 2 + 1;
        s = int'($urandom_range(0, 2 * w)) - w;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        r.steer_in = s[15:0];
      end
    end
    return r;
  endfunction

  // One register write; the predictor copy follows at the same edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_FWD_GEAR:  cfg_model.fwd_gear_code = data[7:0];
      CFG_REV_GEAR:  cfg_model.rev_gear_code = data[7:0];
      CFG_ALLOW_REV: cfg_model.rev_permit    = data[0];
      CFG_MAX_SPEED: cfg_model.max_speed     = data[14:0];
      CFG_MAX_STEER: cfg_model.max_steer     = data[14:0];
      CFG_TIMEOUT:   cfg_model.timeout_ms    = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Unused upper bits of the narrow registers carry junk on purpose
  task automatic apply_settings(input logic [7:0] fwd, input logic [7:0] rev,
                                input logic allow, input logic [14:0] mspd,
                                input logic [14:0] mstr, input logic [15:0] tmo);
    write_reg(CFG_FWD_GEAR,  {8'($urandom), fwd});
    write_reg(CFG_REV_GEAR,  {8'($urandom), rev});
    write_reg(CFG_ALLOW_REV, {15'($urandom), allow});
    write_reg(CFG_MAX_SPEED, {1'($urandom), mspd});
    write_reg(CFG_MAX_STEER, {1'($urandom), mstr});
    write_reg(CFG_TIMEOUT,   tmo);
  endtask

  // Wait for every queued transaction to go in and every result to come out,
  // then let a trailing store settle.
  task automatic drain();
    while (pending_q.size() != 0 || req_accepts != req_issued || result_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_model = '{fwd_gear_code: GEAR_DRIVE, rev_gear_code: GEAR_REVERSE, rev_permit: 1'b0,
                  max_speed: 15'd1000, max_steer: 15'd2500, timeout_ms: 16'd500};
    drop_held();
    held_ms    = '0;
    last_ms    = '0;
    clock_seen = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset settings: no reverse, 1000 mm/s, 25 deg, 500 ms
    pending_q.push_back(mk(ACT_SEND,  32'd0,  0, 0, GEAR_DRIVE, 0, 0, 0)); // nothing held
    pending_q.push_back(mk(ACT_STORE, 32'd10, 0, 0, GEAR_DRIVE, 500, 100, 7));
    pending_q.push_back(mk(ACT_SEND,  32'd10, 0, 0, GEAR_DRIVE, 0, 0, 0));
    pending_q.push_back(mk(ACT_STORE, 32'd20, 0, 0, GEAR_DRIVE, 32767, 32767, 8'hFF));
    pending_q.push_back(mk(ACT_SEND,  32'd20, 0, 0, GEAR_DRIVE, 0, 0, 0)); // both clamped
    pending_q.push_back(mk(ACT_STORE, 32'd30, 0, 0, GEAR_DRIVE, 1, -32768, 0));
    pending_q.push_back(mk(ACT_SEND,  32'd30, 0, 0, GEAR_DRIVE, 0, 0, 0)); // steer at -limit
    pending_q.push_back(mk(ACT_STORE, 32'd40, 0, 0, GEAR_REVERSE, 100, 0, 1)); // not allowed
    pending_q.push_back(mk(ACT_SEND,  32'd40, 0, 0, GEAR_DRIVE, 0, 0, 0));
    pending_q.push_back(mk(ACT_STORE, 32'd50, 0, 0, GEAR_PARK, 0, 1234, 9)); // steer zeroed
    pending_q.push_back(mk(ACT_SEND,  32'd50, 0, 0, GEAR_DRIVE, 0, 0, 0));
    pending_q.push_back(mk(ACT_STORE, 32'd60, 0, 0, GEAR_NEUTRAL, 5, 0, 0)); // moving still gear
    pending_q.push_back(mk(ACT_STORE, 32'd60, 0, 0, GEAR_DRIVE + 8'd1, 10, 0, 0));
    pending_q.push_back(mk(ACT_STORE, 32'd60, 0, 0, 8'hFF, 10, 0, 0));
    pending_q.push_back(mk(ACT_STORE, 32'd70, 0, 1, GEAR_DRIVE, 100, 0, 0)); // non-finite
    pending_q.push_back(mk(ACT_STORE, 32'd70, 0, 0, GEAR_DRIVE, -32768, 0, 0)); // negative
    pending_q.push_back(mk(ACT_STORE, 32'd70, 0, 0, GEAR_DISABLE, 0, -5, 2));
    pending_q.push_back(mk(ACT_SEND,  32'd70, 0, 0, GEAR_DRIVE, 0, 0, 0));
    pending_q.push_back(mk(ACT_STORE, 32'd80, 0, 0, GEAR_DRIVE, 0, 999, 4)); // zero speed
    pending_q.push_back(mk(ACT_SEND,  32'd580, 0, 0, GEAR_DRIVE, 0, 0, 0)); // age = timeout
    pending_q.push_back(mk(ACT_SEND,  32'd581, 0, 0, GEAR_DRIVE, 0, 0, 0)); // stale
    pending_q.push_back(mk(ACT_SEND,  32'd581, 0, 0, GEAR_DRIVE, 0, 0, 0)); // already dropped
    pending_q.push_back(mk(ACT_STORE, 32'd1000, 0, 0, GEAR_DRIVE, 200, 50, 3));
    pending_q.push_back(mk(ACT_SEND,  32'd999, 0, 0, GEAR_DRIVE, 0, 0, 0)); // clock went back
    pending_q.push_back(mk(ACT_SEND,  32'd2000, 1, 0, GEAR_DRIVE, 0, 0, 0)); // bad clock
    pending_q.push_back(mk(ACT_STORE, 32'd5, 0, 0, GEAR_DRIVE, 300, -50, 1)); // fresh reference
    pending_q.push_back(mk(ACT_SEND,  32'd5, 0, 0, GEAR_DRIVE, 0, 0, 0));
    drain();
    stim_ms = 32'd5;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_settings(GEAR_DRIVE, GEAR_REVERSE, 1'b1, 15'h7FFF, 15'h7FFF, 16'hFFFF);
        1: apply_settings(GEAR_DRIVE, GEAR_REVERSE, 1'b0, 15'd0, 15'd0, 16'd0);
        2: apply_settings(8'($urandom_range(0, 3)), GEAR_REVERSE, 1'b1, 15'd1000, 15'd18000,
                          16'd100);
        3: apply_settings(GEAR_DRIVE, 8'hFF, 1'b1, 15'd5000, 15'd18000, 16'd1000);
        4: begin
          apply_settings($urandom_range(0, 1) ? GEAR_DRIVE : 8'($urandom), 8'($urandom),
                         1'($urandom), 15'($urandom), 15'($urandom_range(0, 18000)),
                         16'($urandom_range(0, 2000)));
          write_reg(REG_SPARE_LO, 16'($urandom));
          write_reg(REG_SPARE_HI, 16'($urandom));
        end
        default: apply_settings(GEAR_DRIVE, GEAR_REVERSE, 1'b1, 15'($urandom_range(1, 32767)),
                                15'($urandom_range(0, 18000)), 16'($urandom_range(0, 800)));
      endcase
      idling_on = (p != 3); // one phase back to back on both sides
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_q.push_back(random_item());
      drain();
    end

    if (mismatches == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dcsg_pkg.sv
rtl/dcsg_stream_if.sv
rtl/dcsg_front.sv
rtl/dcsg_queue.sv
rtl/drive_command_safety_gate_core.sv
tb/sv/tb_drive_command_safety_gate_core.sv
